[hw/rtl/commodity_channel_index_macros.svh]
// ----------------------------------------------------------------------------
// commodity_channel_index_macros
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef COMMODITY_CHANNEL_INDEX_MACROS_SVH
`define COMMODITY_CHANNEL_INDEX_MACROS_SVH

// Assert an implication every clock edge outside reset.
`define CCI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert an implication that must also hold during reset.
`define CCI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cci_pkg.sv]
// ----------------------------------------------------------------------------
// cci_pkg
// Shared types and constants of the commodity channel index block.
// ----------------------------------------------------------------------------
package cci_pkg;

  localparam int unsigned DefaultWindow = 20;
  localparam int unsigned PriceW        = 32;
  // 0.015 = 3/200; Q16.16 scale times 200
  localparam logic [23:0] CciScale      = 24'd13107200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TP,
    ST_UPDATE,
    ST_AVG,
    ST_DEV,
    ST_MD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

endpackage

[hw/rtl/cci_divider.sv]
// ----------------------------------------------------------------------------
// cci_divider
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
`include "commodity_channel_index_macros.svh"
module cci_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cci_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic [63:0]         quot_o
);
  import cci_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  `CCI_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `CCI_ASSERT(a_no_restart, clk_i, rst_ni, busy_q |-> !req_i.start, "divider restarted")
  `CCI_ASSERT_ALWAYS(a_done_pulse, clk_i, done_q |=> !done_q, "done held")

endmodule

[hw/rtl/commodity_channel_index.sv]
// Steps once the window is full: typical price, update, average, deviation scan over
// the window, its mean, then the divider. Zero deviation skips the divider; before
// the window fills, the update goes straight to the output.
// One bar in flight: the next is taken only after the result has left.
// Reset: asynchronous, active low; clears counters, sum and control, not the window.
// ----------------------------------------------------------------------------
// commodity_channel_index
// Typical price, moving average, mean deviation and CCI over a price window.
// ----------------------------------------------------------------------------
`include "commodity_channel_index_macros.svh"
module commodity_channel_index #(
  parameter int unsigned WINDOW = cci_pkg::DefaultWindow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] high_price_i,
  input  logic [31:0] low_price_i,
  input  logic [31:0] close_price_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] typical_price_o,
  output logic [31:0] moving_average_o,
  output logic [31:0] mean_deviation_o,
  output logic signed [31:0] index_value_o,
  output logic        window_full_o,
  output logic        zero_deviation_o
);
  import cci_pkg::*;

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned SumW = 32 + CntW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW);
  // divide by WINDOW: multiply by ceil(2^RecK / WINDOW), in two halves
  localparam int unsigned RecK = SumW + CntW;
  localparam int unsigned RecW = SumW + 2;
  localparam int unsigned LoW  = (SumW + 1) / 2;
  localparam int unsigned HiW  = SumW - LoW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << RecK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  // inverse of 3 modulo 2^32
  localparam logic [31:0] InvThree = 32'hAAAA_AAAB;

  logic [31:0] mem [WINDOW];
  logic [31:0] rd_data_q;

  state_e state_q, state_d;
  logic [IdxW-1:0] slot_q, slot_d, scan_q, scan_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic [SumW-1:0] sum_q, sum_d, dev_q, dev_d;
  logic [31:0] tp_q, tp_d, sma_q, sma_d, md_q, md_d, cci_q, cci_d;
  logic        full_q, full_d, zdev_q, zdev_d, neg_q, neg_d;
  logic        rd_vld_q, rd_vld_d;
  logic        phase_q, phase_d;
  logic [33:0] s3_q, s3_d;
  logic [LoW+RecW-1:0]  pp_q, pp_d;
  logic [SumW-1:0]      wd_x;
  logic [HiW+RecW-1:0]  hi_prod;
  logic [SumW+RecW-1:0] wd_prod;
  logic [31:0] wd_quot;
  logic        mem_we;
  logic [IdxW-1:0] rd_addr;
  logic [33:0] tp_sum;
  logic [31:0] absd, mag;
  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot;

  // Residue mod 3 from base-4 digit sums.
  function automatic logic [1:0] mod_three(logic [33:0] x);
    logic [5:0] acc;
    logic [3:0] fold;
    acc = '0;
    for (int k = 0; k < 17; k++) acc = acc + 6'(x[2*k +: 2]);
    fold = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
    if (fold >= 4'd6) fold = fold - 4'd6;
    if (fold >= 4'd3) fold = fold - 4'd3;
    return fold[1:0];
  endfunction

  assign tp_sum = {2'b0, high_price_i} + {2'b0, low_price_i} + {2'b0, close_price_i};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_TP;
      ST_TP:     state_d = ST_UPDATE;
      ST_UPDATE: state_d = (seen_q == FullCnt || seen_q == CntW'(WINDOW - 1)) ? ST_AVG
                                                                          : ST_OUT;
      ST_AVG:    if (phase_q) state_d = ST_DEV;
      ST_DEV:    if (rd_vld_q && scan_q == '0 && !rd_vld_d) state_d = ST_MD;
      ST_MD:     if (phase_q) state_d = ST_DIV;
      ST_DIV:    if (zdev_d || ddone) state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign absd = (rd_data_q >= sma_q) ? rd_data_q - sma_q : sma_q - rd_data_q;
  assign mag  = neg_q ? sma_q - tp_q : tp_q - sma_q;

  assign wd_x    = (state_q == ST_MD) ? dev_q : sum_q;
  assign hi_prod = (HiW+RecW)'(wd_x[SumW-1:LoW]) * (HiW+RecW)'(Recip);
  assign wd_prod = (SumW+RecW)'(pp_q) + ((SumW+RecW)'(hi_prod) << LoW);
  assign wd_quot = wd_prod[RecK +: 32];

  always_comb begin
    slot_d = slot_q; scan_d = scan_q; seen_d = seen_q; sum_d = sum_q;
    dev_d = dev_q; tp_d = tp_q; sma_d = sma_q; md_d = md_q; cci_d = cci_q;
    full_d = full_q; zdev_d = zdev_q; neg_d = neg_q;
    phase_d = phase_q; s3_d = s3_q; pp_d = pp_q;
    rd_vld_d = 1'b0; mem_we = 1'b0; rd_addr = slot_q;
    dreq = '0;
    unique case (state_q)
      ST_IDLE: begin
        s3_d = tp_sum;
        rd_addr = slot_q;
      end
      ST_TP: begin
        // exact divide: drop the remainder, then multiply by the inverse of 3
        tp_d = (s3_q[31:0] - 32'(mod_three(s3_q))) * InvThree;
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        sum_d = sum_q + SumW'(tp_q) - ((seen_q == FullCnt) ? SumW'(rd_data_q) : '0);
        if (seen_q != FullCnt) seen_d = seen_q + 1'b1;
        slot_d = (slot_q == LastIdx) ? '0 : slot_q + 1'b1;
        full_d = (seen_q == FullCnt) || (seen_q == CntW'(WINDOW - 1));
        sma_d = '0; md_d = '0; cci_d = '0; zdev_d = 1'b0;
        if (full_d) dev_d = '0;
        if (seen_q != FullCnt && full_d) seen_d = FullCnt;
      end
      ST_AVG: begin
        if (!phase_q) begin
          pp_d = (LoW+RecW)'(wd_x[LoW-1:0]) * (LoW+RecW)'(Recip);
          phase_d = 1'b1;
        end else begin
          sma_d = wd_quot;
          phase_d = 1'b0;
          rd_addr = LastIdx;
          rd_vld_d = 1'b1;
          scan_d = LastIdx;
        end
      end
      ST_DEV: begin
        dev_d = dev_q + SumW'(absd);
        if (scan_q != '0) begin
          scan_d = scan_q - 1'b1;
          rd_addr = scan_q - 1'b1;
          rd_vld_d = 1'b1;
        end
        neg_d = tp_q < sma_q;
      end
      ST_MD: begin
        if (!phase_q) begin
          pp_d = (LoW+RecW)'(wd_x[LoW-1:0]) * (LoW+RecW)'(Recip);
          phase_d = 1'b1;
        end else begin
          md_d = wd_quot;
          phase_d = 1'b0;
          zdev_d = (md_d == '0);
          dreq.start = (md_d != '0);
          dreq.dividend = 64'(mag) * 64'(CciScale);
          dreq.divisor = 64'(md_d) * 64'd3;
        end
      end
      ST_DIV: begin
        if (zdev_q) cci_d = '0;
        else if (ddone) begin
          if (neg_q) cci_d = (dquot >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-dquot);
          else cci_d = (dquot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dquot[31:0];
        end
        zdev_d = zdev_q;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  cci_divider u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(dreq), .done_o(ddone), .quot_o(dquot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[slot_q] <= tp_q;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; slot_q <= '0; seen_q <= '0; sum_q <= '0;
      scan_q <= '0; rd_vld_q <= 1'b0; phase_q <= 1'b0;
    end else begin
      state_q <= state_d; slot_q <= slot_d; seen_q <= seen_d; sum_q <= sum_d;
      scan_q <= scan_d; rd_vld_q <= rd_vld_d; phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q <= dev_d; tp_q <= tp_d; sma_q <= sma_d; md_q <= md_d; cci_q <= cci_d;
    full_q <= full_d; zdev_q <= zdev_d; neg_q <= neg_d;
    s3_q <= s3_d; pp_q <= pp_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = (state_q == ST_OUT);
  assign typical_price_o  = tp_q;
  assign moving_average_o = sma_q;
  assign mean_deviation_o = md_q;
  assign index_value_o    = cci_q;
  assign window_full_o    = full_q;
  assign zero_deviation_o = zdev_q;

  `CCI_ASSERT(a_seen_bound, clk_i, rst_ni, seen_q <= FullCnt, "bar count overflow")
  `CCI_ASSERT(a_slot_bound, clk_i, rst_ni, slot_q <= LastIdx, "slot out of range")
  `CCI_ASSERT(a_zdev_full, clk_i, rst_ni, zdev_q && out_valid_o |-> full_q, "zdev early")

endmodule
